[design/bfa_pkg.sv]
package bfa_pkg;

	localparam int OP_W       = 1;
	localparam int IDX_W      = 7;
	localparam int AMT_W      = 16;
	localparam int RSP_SIZE_W = 16;
	localparam int CNT_W      = 8;

	localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
	localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

	typedef struct packed {
		logic valid;
		logic have;
	} tok_ctl_t;

	typedef struct packed {
		logic en;
		logic free;
	} wr_ctl_t;

endpackage

[design/bfa_req_if.sv]
interface bfa_req_if;
	import bfa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [IDX_W-1:0]     entry_index;
	logic [AMT_W-1:0]     amount;

	modport source (output valid, operation, entry_index, amount, input ready);
	modport sink   (input valid, operation, entry_index, amount, output ready);

endinterface

[design/bfa_rsp_if.sv]
interface bfa_rsp_if;
	import bfa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [IDX_W-1:0]      block_index;
	logic [RSP_SIZE_W-1:0] block_size;
	logic [RSP_SIZE_W-1:0] remaining;

	modport source (output valid, found, block_index, block_size, remaining, input ready);
	modport sink   (input valid, found, block_index, block_size, remaining, output ready);

endinterface

[design/bfa_cell.sv]
module bfa_cell #(
	parameter int CELL_IDX   = 0,
	parameter int IW         = 7,
	parameter int SIZE_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [bfa_pkg::CNT_W-1:0] block_count,
	input  bfa_pkg::tok_ctl_t        tin_ctl,
	input  logic [IW-1:0]            tin_idx,
	input  logic [SIZE_WIDTH-1:0]    tin_size,
	input  logic [SIZE_WIDTH-1:0]    tin_amt,
	output bfa_pkg::tok_ctl_t        tout_ctl,
	output logic [IW-1:0]            tout_idx,
	output logic [SIZE_WIDTH-1:0]    tout_size,
	output logic [SIZE_WIDTH-1:0]    tout_amt,
	input  bfa_pkg::wr_ctl_t         wr_ctl,
	input  logic [IW-1:0]            wr_idx,
	input  logic [SIZE_WIDTH-1:0]    wr_size
);
	import bfa_pkg::*;

	logic [SIZE_WIDTH-1:0] size_q;
	logic                  free_q;
	logic                  in_range;
	logic                  hit;
	logic                  wr_sel;

	assign in_range = (32'(block_count) > 32'(CELL_IDX));
	assign hit = tin_ctl.valid && in_range && free_q && (size_q >= tin_amt)
		&& (!tin_ctl.have || (size_q < tin_size));
	assign wr_sel = wr_ctl.en && (wr_idx == IW'(CELL_IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= 1'b0;
			tout_ctl <= '0;
		end else begin
			if (wr_sel) begin
				free_q <= wr_ctl.free;
			end
			tout_ctl.valid <= tin_ctl.valid;
			tout_ctl.have  <= tin_ctl.have || hit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			size_q <= wr_size;
		end
		tout_amt <= tin_amt;
		if (hit) begin
			tout_idx  <= IW'(CELL_IDX);
			tout_size <= size_q;
		end else begin
			tout_idx  <= tin_idx;
			tout_size <= tin_size;
		end
	end

endmodule

[design/best_fit_block_allocator.sv]
// Best-fit block allocator. Requests arrive on the req channel as words with an operation,
// an entry index and an amount; one result word leaves on the rsp channel for every request.
// A load writes the size of one table entry and marks it free; its result echoes the entry.
// An allocate searches entries below block_count for the smallest free block that holds the
// request, lowest index first on a tie, marks it allocated and reduces its size.
// The table lives in a row of NUM_BLOCKS cells; a search token enters the first cell and
// moves one cell per clock. An allocate passes from the injection register through every
// cell into the holding register, and a load's result goes straight into it.
// One request is in work at a time; req.ready is high while the block is idle, even when a
// finished result still waits in the output register. If the receiver stalls, the result
// stays in the output register and the next result waits in the holding register, so no new
// request is taken until the output register frees up. The user must write block_count
// through cfg_we and cfg_wdata only while the block is idle; the block itself does not
// enforce this. Reset clears block_count and all free flags, so no entry can be allocated
// until loaded.
module best_fit_block_allocator #(
	parameter int NUM_BLOCKS = 128,
	parameter int SIZE_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bfa_pkg::CNT_W-1:0] cfg_wdata,
	bfa_req_if.sink                   req,
	bfa_rsp_if.source                 rsp
);
	import bfa_pkg::*;

	localparam int IW = $clog2(NUM_BLOCKS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  inj_valid_q;
	logic [SIZE_WIDTH-1:0] inj_amt_q;

	logic                  res_found_q;
	logic [IW-1:0]         res_idx_q;
	logic [SIZE_WIDTH-1:0] res_size_q;
	logic [SIZE_WIDTH-1:0] res_rem_q;

	logic                  rsp_valid_q;
	logic                  rsp_found_q;
	logic [IDX_W-1:0]      rsp_idx_q;
	logic [RSP_SIZE_W-1:0] rsp_size_q;
	logic [RSP_SIZE_W-1:0] rsp_rem_q;

	tok_ctl_t              tok_ctl  [0:NUM_BLOCKS];
	logic [IW-1:0]         tok_idx  [0:NUM_BLOCKS];
	logic [SIZE_WIDTH-1:0] tok_size [0:NUM_BLOCKS];
	logic [SIZE_WIDTH-1:0] tok_amt  [0:NUM_BLOCKS];

	wr_ctl_t               wr_ctl;
	logic [IW-1:0]         wr_idx;
	logic [SIZE_WIDTH-1:0] wr_size;

	logic                  accept;
	logic                  is_load;
	logic                  load_ok;
	logic [SIZE_WIDTH-1:0] amt_m;
	logic                  scan_done;
	logic [SIZE_WIDTH-1:0] scan_rem;
	logic                  out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_load   = (req.operation == OP_LOAD);
	assign load_ok   = (32'(req.entry_index) < 32'(NUM_BLOCKS));
	assign amt_m     = SIZE_WIDTH'(req.amount);
	assign scan_done = (state_q == ST_SCAN) && tok_ctl[NUM_BLOCKS].valid;
	assign scan_rem  = tok_size[NUM_BLOCKS] - tok_amt[NUM_BLOCKS];
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign tok_ctl[0]  = '{valid: inj_valid_q, have: 1'b0};
	assign tok_idx[0]  = '0;
	assign tok_size[0] = '0;
	assign tok_amt[0]  = inj_amt_q;

	always_comb begin
		wr_ctl  = '0;
		wr_idx  = IW'(req.entry_index);
		wr_size = amt_m;
		priority if (scan_done) begin
			wr_ctl.en   = tok_ctl[NUM_BLOCKS].have;
			wr_ctl.free = 1'b0;
			wr_idx      = tok_idx[NUM_BLOCKS];
			wr_size     = scan_rem;
		end else if (accept && is_load) begin
			wr_ctl.en   = load_ok;
			wr_ctl.free = 1'b1;
		end
	end

	for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
		bfa_cell #(
			.CELL_IDX   (k),
			.IW         (IW),
			.SIZE_WIDTH (SIZE_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.block_count (cnt_q),
			.tin_ctl     (tok_ctl[k]),
			.tin_idx     (tok_idx[k]),
			.tin_size    (tok_size[k]),
			.tin_amt     (tok_amt[k]),
			.tout_ctl    (tok_ctl[k+1]),
			.tout_idx    (tok_idx[k+1]),
			.tout_size   (tok_size[k+1]),
			.tout_amt    (tok_amt[k+1]),
			.wr_ctl      (wr_ctl),
			.wr_idx      (wr_idx),
			.wr_size     (wr_size)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			inj_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cnt_q <= cfg_wdata;
			end
			inj_valid_q <= accept && !is_load;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= is_load ? ST_HOLD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok_ctl[NUM_BLOCKS].valid) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_HOLD && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inj_amt_q <= amt_m;
		end
		if (accept && is_load) begin
			res_found_q <= load_ok;
			res_idx_q   <= load_ok ? IW'(req.entry_index) : '0;
			res_size_q  <= load_ok ? amt_m : '0;
			res_rem_q   <= load_ok ? amt_m : '0;
		end else if (scan_done) begin
			res_found_q <= tok_ctl[NUM_BLOCKS].have;
			res_idx_q   <= tok_ctl[NUM_BLOCKS].have ? tok_idx[NUM_BLOCKS] : '0;
			res_size_q  <= tok_ctl[NUM_BLOCKS].have ? tok_size[NUM_BLOCKS] : '0;
			res_rem_q   <= tok_ctl[NUM_BLOCKS].have ? scan_rem : '0;
		end
		if (state_q == ST_HOLD && out_free) begin
			rsp_found_q <= res_found_q;
			rsp_idx_q   <= IDX_W'(res_idx_q);
			rsp_size_q  <= RSP_SIZE_W'(res_size_q);
			rsp_rem_q   <= RSP_SIZE_W'(res_rem_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.block_index = rsp_idx_q;
	assign rsp.block_size  = rsp_size_q;
	assign rsp.remaining   = rsp_rem_q;

endmodule

[design/bfa_checker.sv]
module bfa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [bfa_pkg::OP_W-1:0]       req_operation,
	input logic [bfa_pkg::IDX_W-1:0]      req_entry_index,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           rsp_found,
	input logic [bfa_pkg::IDX_W-1:0]      rsp_block_index,
	input logic [bfa_pkg::RSP_SIZE_W-1:0] rsp_block_size,
	input logic [bfa_pkg::RSP_SIZE_W-1:0] rsp_remaining
);
	import bfa_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
			&& $stable(rsp_block_index) && $stable(rsp_block_size) && $stable(rsp_remaining))
		else $error("Stalled result word changed.");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request taken while another is in work.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_block_index == '0 && rsp_block_size == '0
			&& rsp_remaining == '0)
		else $error("Result without a block carries nonzero fields.");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_remaining <= rsp_block_size)
		else $error("Remaining size exceeds block size.");

	a_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_operation == OP_LOAD && (!rsp_valid || rsp_ready)
			|-> ##2 rsp_valid && (!rsp_found || rsp_block_index == $past(req_entry_index, 2)))
		else $error("Load result does not echo its entry.");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_operation   (req.operation),
	.req_entry_index (req.entry_index),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_block_index (rsp.block_index),
	.rsp_block_size  (rsp.block_size),
	.rsp_remaining   (rsp.remaining)
);

[verif/best_fit_block_allocator_tb.sv]
`timescale 1ns / 100ps
module best_fit_block_allocator_tb;
	import bfa_pkg::*;

	localparam int NUM_BLOCKS   = 128;
	localparam int SIZE_WIDTH   = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = NUM_BLOCKS + 8;

	typedef struct packed {
		logic                  found;
		logic [IDX_W-1:0]      block_index;
		logic [RSP_SIZE_W-1:0] block_size;
		logic [RSP_SIZE_W-1:0] remaining;
	} alloc_result_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	bfa_req_if req_bus ();
	bfa_rsp_if rsp_bus ();

	best_fit_block_allocator #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_bus),
		.rsp      (rsp_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [SIZE_WIDTH-1:0] size_of_block [NUM_BLOCKS];
	bit                    block_free [NUM_BLOCKS];
	int unsigned           search_count;
	alloc_result_t         pending_results [$];
	int unsigned           mismatches;
	int unsigned           cycle_count;
	bit                    sender_idling;
	bit                    receiver_idling;
	int unsigned           hold_left;
	int unsigned           stall_left;

	function automatic alloc_result_t predict_result(logic op, logic [IDX_W-1:0] idx,
			logic [AMT_W-1:0] amt);
		alloc_result_t r;
		int unsigned   lim;
		bit            have;
		int            best;
		r = '0;
		if (op == OP_LOAD) begin
			size_of_block[idx] = amt;
			block_free[idx]    = 1'b1;
			r.found            = 1'b1;
			r.block_index      = idx;
			r.block_size       = amt;
			r.remaining        = amt;
			return r;
		end
		lim  = (search_count > NUM_BLOCKS) ? NUM_BLOCKS : search_count;
		have = 1'b0;
		best = 0;
		for (int i = 0; i < lim; i++) begin
			if (block_free[i] && size_of_block[i] >= amt &&
					(!have || size_of_block[i] < size_of_block[best])) begin
				have = 1'b1;
				best = i;
			end
		end
		if (have) begin
			block_free[best]    = 1'b0;
			r.found             = 1'b1;
			r.block_index       = IDX_W'(best);
			r.block_size        = size_of_block[best];
			r.remaining         = size_of_block[best] - amt;
			size_of_block[best] = r.remaining;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: block_index %0d, block_size %0d",
						rsp_bus.block_index, rsp_bus.block_size);
			end else begin
				want = pending_results.pop_front();
				check_field("found", 32'(want.found), 32'(rsp_bus.found));
				check_field("block_index", 32'(want.block_index), 32'(rsp_bus.block_index));
				check_field("block_size", 32'(want.block_size), 32'(rsp_bus.block_size));
				check_field("remaining", 32'(want.remaining), 32'(rsp_bus.remaining));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_bus.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			rsp_bus.ready <= 1'b0;
			stall_left--;
		end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
			rsp_bus.ready <= 1'b0;
			stall_left = $urandom_range(0, 11);
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("best_fit_block_allocator_tb: errors");
			$finish;
		end
	end

	task automatic send_word(logic op, logic [IDX_W-1:0] idx, logic [AMT_W-1:0] amt);
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_bus.valid       <= 1'b1;
		req_bus.operation   <= op;
		req_bus.entry_index <= idx;
		req_bus.amount      <= amt;
		do @(posedge clk); while (!req_bus.ready);
		pending_results.push_back(predict_result(op, idx, amt));
	endtask

	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0 || !req_bus.ready);
		@(posedge clk);
	endtask

	task automatic write_block_count(int unsigned value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(value);
		@(posedge clk);
		cfg_we       <= 1'b0;
		search_count  = value;
	endtask

	task automatic send_random_word();
		int unsigned      lim;
		int unsigned      pick;
		logic [IDX_W-1:0] idx;
		logic [AMT_W-1:0] amt;
		int               candidates [$];
		lim = (search_count > NUM_BLOCKS) ? NUM_BLOCKS : search_count;
		idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
		amt = AMT_W'($urandom_range(0, 16'hFFFF));
		if ($urandom_range(0, 99) < 45) begin
			if (lim > 0 && $urandom_range(0, 3) != 0)
				idx = IDX_W'($urandom_range(0, lim - 1));
			case ($urandom_range(0, 4))
				0: amt = AMT_W'($urandom_range(0, 64));
				1: amt = AMT_W'($urandom_range(0, 1000));
				2: amt = $urandom_range(0, 1) ? '1 : '0;
				default: ;
			endcase
			send_word(OP_LOAD, idx, amt);
		end else begin
			for (int i = 0; i < lim; i++)
				if (block_free[i])
					candidates.push_back(i);
			pick = $urandom_range(0, 9);
			if (candidates.size() > 0 && pick < 7) begin
				amt = size_of_block[candidates[$urandom_range(0, candidates.size() - 1)]];
				if (pick >= 3 && pick < 6 && amt != 0)
					amt = amt - AMT_W'($urandom_range(1, (amt < 8) ? amt : 8));
				else if (pick == 6)
					amt = amt + 1'b1;
			end else if (pick == 7) begin
				amt = '0;
			end else if (pick == 8) begin
				amt = AMT_W'($urandom_range(0, 100));
			end
			send_word(OP_ALLOC, idx, amt);
		end
	endtask

	task automatic test_fill_table();
		logic [AMT_W-1:0] amt;
		write_block_count(NUM_BLOCKS);
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			amt = AMT_W'($urandom_range(1, 2000));
			if (i == 0)
				amt = '1;
			else if (i == NUM_BLOCKS - 1)
				amt = '0;
			send_word(OP_LOAD, IDX_W'(i), amt);
		end
	endtask

	task automatic test_directed();
		write_block_count(4);
		send_word(OP_LOAD, 0, 300);
		send_word(OP_LOAD, 1, 100);
		send_word(OP_LOAD, 2, 100);
		send_word(OP_LOAD, 3, '1);
		send_word(OP_ALLOC, 0, 100);
		send_word(OP_ALLOC, '1, 100);
		send_word(OP_ALLOC, 0, 50);
		send_word(OP_ALLOC, 0, 0);
		send_word(OP_ALLOC, 0, 1);
		send_word(OP_LOAD, 1, 0);
		send_word(OP_ALLOC, 0, 0);
		send_word(OP_LOAD, 3, '1);
		send_word(OP_ALLOC, 0, '1);
		write_block_count(0);
		send_word(OP_ALLOC, 0, 0);
		write_block_count(255);
		send_word(OP_LOAD, IDX_W'(NUM_BLOCKS - 1), '1);
		send_word(OP_ALLOC, 0, '1);
		write_block_count(NUM_BLOCKS);
		send_word(OP_ALLOC, 0, 0);
		write_block_count(1);
		send_word(OP_ALLOC, 0, 0);
	endtask

	task automatic test_random_phases();
		int unsigned counts [10] = '{1, 2, 8, 32, 128, 200, 255, 0, 16, 128};
		counts[7]       = $urandom_range(3, NUM_BLOCKS - 1);
		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		foreach (counts[p]) begin
			write_block_count(counts[p]);
			repeat (85) send_random_word();
		end
	endtask

	task automatic test_long_hold();
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		write_block_count(NUM_BLOCKS);
		@(negedge clk);
		hold_left = 300;
		@(posedge clk);
		repeat (24) send_random_word();
	endtask

	task automatic test_sender_pause();
		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		repeat (12) send_random_word();
		wait_idle();
		repeat (12) send_random_word();
	endtask

	task automatic test_back_to_back();
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		write_block_count($urandom_range(8, NUM_BLOCKS));
		repeat (100) send_random_word();
	endtask

	initial begin
		req_bus.valid       = 1'b0;
		req_bus.operation   = OP_LOAD;
		req_bus.entry_index = '0;
		req_bus.amount      = '0;
		rsp_bus.ready       = 1'b0;
		search_count        = 0;
		foreach (block_free[i]) begin
			block_free[i]    = 1'b0;
			size_of_block[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_table();
		test_directed();
		test_random_phases();
		test_long_hold();
		test_sender_pause();
		test_back_to_back();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("best_fit_block_allocator_tb: clean");
		else
			$display("best_fit_block_allocator_tb: errors");
		$finish;
	end

endmodule
